@@ hw/rtl/utf8_to_utf32_stream_decoder_top_assert.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_TO_UTF32_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF32_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define U2U_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("u2u assertion failed");

// Next-cycle implication, disabled during reset.
`define U2U_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("u2u assertion failed");

`endif

@@ hw/rtl/u2u_pkg.sv @@
// Types, codes and decode helpers for the UTF-8 to UTF-32 decoder.
package u2u_pkg;

	localparam int Q_DEPTH = 4;

	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_TRUNC   = 2'd1;
	localparam logic [1:0] ERR_BADCONT = 2'd2;
	localparam logic [1:0] ERR_INVALID = 2'd3;

	localparam logic [30:0] REPL_CP = 31'h0000FFFD;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_beat_t;

	typedef struct packed {
		logic [30:0] code_point;
		logic [2:0]  seq_len;
		logic [1:0]  error_kind;
		logic        last_of_run;
	} out_beat_t;

	// Results of one byte, packed from slot 0.
	typedef struct packed {
		logic      vld0;
		logic      vld1;
		out_beat_t beat0;
		out_beat_t beat1;
	} q_push_t;

	function automatic logic [2:0] lead_count(input logic [7:0] b);
		logic [2:0] c;
		case (b) inside
			[8'h00:8'hBF]: c = 3'd0;
			[8'hC0:8'hDF]: c = 3'd1;
			[8'hE0:8'hEF]: c = 3'd2;
			[8'hF0:8'hF7]: c = 3'd3;
			[8'hF8:8'hFB]: c = 3'd4;
			default:       c = 3'd5;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] lead_mask(input logic [2:0] c);
		logic [7:0] m;
		case (c)
			3'd0:    m = 8'h7F;
			3'd1:    m = 8'h1F;
			3'd2:    m = 8'h0F;
			3'd3:    m = 8'h07;
			3'd4:    m = 8'h03;
			default: m = 8'h01;
		endcase
		return m;
	endfunction

	// Overlong, surrogate, range and length checks on a finished sequence; flags only when strict.
	function automatic logic invalid_cp(input logic [30:0] ch, input logic [2:0] c,
			input logic strict);
		logic bad;
		bad = (ch > 31'h0010FFFF) ||
			(ch >= 31'h0000D800 && ch <= 31'h0000DFFF) ||
			(c > 3'd3) ||
			(c == 3'd1 && ch <= 31'h0000007F) ||
			(c == 3'd2 && ch <= 31'h000007FF) ||
			(c == 3'd3 && ch <= 31'h0000FFFF);
		return strict & bad;
	endfunction

endpackage

@@ hw/rtl/utf8_to_utf32_stream_decoder_top.sv @@
// UTF-8 byte stream to UTF-32 code point decoder, top level with config port.
// With the queue empty, a byte's result goes to a queue slot, then the output register.
// Throughput: one byte per cycle; the front end stalls while the result queue
// has room for fewer than two beats; output drains one beat per cycle unless cp_stall.
// A byte that breaks a sequence can yield two beats: the error beat and its own lead beat.
// Reset (arst_n low, asynchronous) idles the decoder, empties the queue, clears strict_q.
module utf8_to_utf32_stream_decoder_top #(
	parameter int Q_DEPTH = u2u_pkg::Q_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  u2u_pkg::in_beat_t   byte_data,
	output logic                cp_valid,
	input  logic                cp_stall,
	output u2u_pkg::out_beat_t  cp_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import u2u_pkg::*;

	localparam logic ADDR_STRICT = 1'b0;

	logic      strict_q;
	logic      accept;
	logic      room2;
	logic      head_vld;
	logic      pop;
	q_push_t   push;
	out_beat_t head;

	assign pready     = 1'b1;
	assign byte_stall = !room2;
	assign accept     = byte_valid && room2;
	assign prdata     = (paddr[2] == ADDR_STRICT) ? {31'd0, strict_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == ADDR_STRICT) begin
			strict_q <= pwdata[0];
		end
	end

	u2u_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.byte_in(byte_data),
		.strict (strict_q),
		.push   (push)
	);

	u2u_queue #(
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room2   (room2),
		.head_vld(head_vld),
		.head    (head),
		.pop     (pop)
	);

	u2u_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_vld(head_vld),
		.head    (head),
		.pop     (pop),
		.cp_valid(cp_valid),
		.cp_stall(cp_stall),
		.cp_data (cp_data)
	);

endmodule

@@ hw/rtl/u2u_front.sv @@
// Front end: takes bytes, tracks the sequence state and forms result beats.
`include "utf8_to_utf32_stream_decoder_top_assert.svh"

module u2u_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  u2u_pkg::in_beat_t  byte_in,
	input  logic               strict,
	output u2u_pkg::q_push_t   push
);
	import u2u_pkg::*;

	logic [30:0] acc_q;
	logic [2:0]  exp_q;
	logic [2:0]  rcv_q;
	logic        inseq_q;

	logic [30:0] acc_n;
	logic [2:0]  exp_n;
	logic [2:0]  rcv_n;
	logic        inseq_n;

	logic [7:0]  b;
	logic        eos;
	logic [2:0]  lead_c;
	logic [30:0] lead_v;
	logic        lead_vld;
	out_beat_t   lead_beat;
	logic [30:0] cont_acc;
	logic [2:0]  cont_rcv;
	logic        r0_vld;
	logic        r1_vld;
	out_beat_t   r0;
	out_beat_t   r1;

	assign b   = byte_in.data_byte;
	assign eos = byte_in.end_of_stream;

	always_comb begin
		lead_c    = lead_count(b);
		lead_v    = {23'd0, b & lead_mask(lead_c)};
		lead_vld  = 1'b0;
		lead_beat = '0;
		if (lead_c == 3'd0) begin
			lead_vld = 1'b1;
			if (invalid_cp(lead_v, 3'd0, strict)) begin
				lead_beat = '{REPL_CP, 3'd1, ERR_INVALID, 1'b0};
			end else begin
				lead_beat = '{lead_v, 3'd1, ERR_OK, 1'b0};
			end
		end else if (eos) begin
			lead_vld  = 1'b1;
			lead_beat = '{REPL_CP, 3'd1, ERR_TRUNC, 1'b0};
		end

		cont_acc = {acc_q[24:0], b[5:0]};
		cont_rcv = rcv_q + 3'd1;

		r0_vld  = 1'b0;
		r1_vld  = 1'b0;
		r0      = '0;
		r1      = '0;
		acc_n   = '0;
		exp_n   = '0;
		rcv_n   = '0;
		inseq_n = 1'b0;

		if (!inseq_q || (strict && b[7:6] != 2'b10)) begin
			if (inseq_q) begin
				// broken sequence: flag it, then retry the byte as a lead
				r0_vld = 1'b1;
				r0     = '{REPL_CP, rcv_q + 3'd1, ERR_BADCONT, 1'b0};
				r1_vld = lead_vld;
				r1     = lead_beat;
			end else begin
				r0_vld = lead_vld;
				r0     = lead_beat;
			end
			if (!lead_vld) begin
				acc_n   = lead_v;
				exp_n   = lead_c;
				inseq_n = 1'b1;
			end
		end else if (cont_rcv >= exp_q) begin
			r0_vld = 1'b1;
			if (invalid_cp(cont_acc, exp_q, strict)) begin
				r0 = '{REPL_CP, exp_q + 3'd1, ERR_INVALID, 1'b0};
			end else begin
				r0 = '{cont_acc, exp_q + 3'd1, ERR_OK, 1'b0};
			end
		end else if (eos) begin
			r0_vld = 1'b1;
			r0     = '{REPL_CP, cont_rcv + 3'd1, ERR_TRUNC, 1'b0};
		end else begin
			acc_n   = cont_acc;
			exp_n   = exp_q;
			rcv_n   = cont_rcv;
			inseq_n = 1'b1;
		end

		r0.last_of_run = !r1_vld;
		r1.last_of_run = 1'b1;

		push.vld0  = accept & r0_vld;
		push.vld1  = accept & r1_vld;
		push.beat0 = r0;
		push.beat1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			exp_q   <= '0;
			rcv_q   <= '0;
			inseq_q <= 1'b0;
		end else if (accept) begin
			acc_q   <= acc_n;
			exp_q   <= exp_n;
			rcv_q   <= rcv_n;
			inseq_q <= inseq_n;
		end
	end

	`U2U_ASSERT_IMP(a_seq_counts, clk, arst_n, inseq_q, (exp_q != 3'd0) && (rcv_q < exp_q))
	`U2U_ASSERT_IMP(a_second_is_last, clk, arst_n, push.vld1,
		push.vld0 && !push.beat0.last_of_run && push.beat1.last_of_run)

endmodule

@@ hw/rtl/u2u_queue.sv @@
// Result queue between the front end and the output stage; takes up to two beats a cycle.
`include "utf8_to_utf32_stream_decoder_top_assert.svh"

module u2u_queue #(
	parameter int DEPTH = u2u_pkg::Q_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  u2u_pkg::q_push_t    push,
	output logic                room2,
	output logic                head_vld,
	output u2u_pkg::out_beat_t  head,
	input  logic                pop
);
	import u2u_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	out_beat_t     slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] wr1;
	logic [CW-1:0] npush;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr1      = nxt(wr_q);
	assign npush    = CW'(push.vld0) + CW'(push.vld1);
	assign room2    = cnt_q <= CW'(DEPTH - 2);
	assign head_vld = cnt_q != '0;
	assign head     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.vld0) begin
			slot_q[wr_q] <= push.beat0;
		end
		if (push.vld1) begin
			slot_q[wr1] <= push.beat1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.vld1) begin
				wr_q <= nxt(wr1);
			end else if (push.vld0) begin
				wr_q <= wr1;
			end
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			cnt_q <= cnt_q + npush - CW'(pop);
		end
	end

	`U2U_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))
	`U2U_ASSERT_IMP(a_no_overflow, clk, arst_n, push.vld0, room2)
	`U2U_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, head_vld)

endmodule

@@ hw/rtl/u2u_back.sv @@
// Output stage: registered result beat drained from the queue.
module u2u_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_vld,
	input  u2u_pkg::out_beat_t  head,
	output logic                pop,
	output logic                cp_valid,
	input  logic                cp_stall,
	output u2u_pkg::out_beat_t  cp_data
);
	import u2u_pkg::*;

	logic      vld_q;
	out_beat_t beat_q;
	logic      take;

	assign take     = !vld_q || !cp_stall;
	assign pop      = head_vld && take;
	assign cp_valid = vld_q;
	assign cp_data  = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take) begin
			vld_q <= head_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			beat_q <= head;
		end
	end

endmodule
